// File: rtl/pnc_pkg.sv
// Shared types and constants for the palette nearest color search.
// No dependencies; imported by every module of the block except pnc_ram.
package pnc_pkg;

    // Default palette depth and queue depth
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH       = 2;

    // Field widths
    localparam int COUNT_W  = 9;
    localparam int COLOR_W  = 32;
    localparam int CHAN_W   = 8;
    localparam int INDEX_W  = 8;
    localparam int SQ_W     = 16;
    localparam int DIST_W   = 18;
    localparam int RESULT_W = 31;

    // Distance reported when no entry is searched
    localparam logic [RESULT_W-1:0] NO_MATCH_DIST = 31'h7FFF_FFFF;

    // Reset values of the configuration registers
    localparam logic [COUNT_W-1:0] COUNT_RESET       = 9'd256;
    localparam logic [COLOR_W-1:0] TRANSPARENT_RESET = 32'd0;

    // Configuration register indexes
    localparam logic REG_PALETTE_COUNT     = 1'b0;
    localparam logic REG_TRANSPARENT_COLOR = 1'b1;

    // Item kinds
    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_MAP   = 1'b1
    } action_t;

    // One item as held in the queue between front and back
    typedef struct packed {
        action_t                action;
        logic [INDEX_W-1:0]     index;
        logic [COLOR_W-1:0]     pixel;
    } pnc_item_t;

endpackage

// File: rtl/pnc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pnc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/pnc_fifo.sv
// Short item queue between the front and back parts of the search.
// Depends on pnc_pkg for the item type.
module pnc_fifo
    import pnc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pnc_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output pnc_item_t head_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pnc_item_t         entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full       = (fill_reg == CW'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/pnc_front.sv
// Front part: configuration registers, item intake and classification.
// Depends on pnc_pkg; feeds pnc_fifo.
module pnc_front
    import pnc_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [COLOR_W-1:0]                   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 action,
    input  logic [INDEX_W-1:0]                   entry_index,
    input  logic [CHAN_W-1:0]                    alpha,
    input  logic [CHAN_W-1:0]                    red,
    input  logic [CHAN_W-1:0]                    green,
    input  logic [CHAN_W-1:0]                    blue,
    input  logic                                 q_full,
    output logic                                 q_push,
    output pnc_item_t                            q_item,
    output logic [$clog2(PALETTE_DEPTH+1)-1:0]   search_count
);

    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic [COUNT_W-1:0] count_reg;
    logic [COLOR_W-1:0] transparent_reg;
    logic               accept;
    logic               write_in_range;
    logic [COLOR_W-1:0] raw_pixel;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= COUNT_RESET;
            transparent_reg <= TRANSPARENT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PALETTE_COUNT:     count_reg       <= cfg_data[COUNT_W-1:0];
                REG_TRANSPARENT_COLOR: transparent_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Clamp the searched count to the palette depth
    assign search_count = (CMP_W'(count_reg) > CMP_W'(PALETTE_DEPTH))
                        ? CNT_W'(PALETTE_DEPTH) : CNT_W'(count_reg);

    // Accept whenever the queue has room
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Drop writes beyond the palette, substitute transparent pixels
    assign write_in_range = (32'(entry_index) < 32'(PALETTE_DEPTH));
    assign raw_pixel      = {alpha, red, green, blue};

    always_comb
    begin
        q_item.action = action_t'(action);
        q_item.index  = entry_index;
        if (action_t'(action) == ACT_MAP && alpha == '0)
        begin
            q_item.pixel = transparent_reg;
        end
        else
        begin
            q_item.pixel = raw_pixel;
        end
        q_push = accept && (action_t'(action) == ACT_MAP || write_in_range);
    end

endmodule

// File: rtl/pnc_back.sv
// Back part: palette store writes and the sequential nearest-entry scan.
// Depends on pnc_pkg and pnc_ram; takes items from pnc_fifo.
module pnc_back
    import pnc_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [$clog2(PALETTE_DEPTH+1)-1:0]   search_count,
    input  logic                                 q_valid,
    input  pnc_item_t                            q_item,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [INDEX_W-1:0]                   color_index,
    output logic [RESULT_W-1:0]                  best_distance
);

    localparam int AW    = $clog2(PALETTE_DEPTH);
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       addr_reg;
    logic [COLOR_W-1:0]  pixel_reg;
    logic                v1_reg, v2_reg;
    logic [AW-1:0]       idx1_reg, idx2_reg;
    logic [SQ_W-1:0]     sq_reg [4];
    logic [AW-1:0]       best_idx_reg;
    logic [RESULT_W-1:0] best_dist_reg;
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [RESULT_W-1:0] out_dist_reg;

    logic                ram_we;
    logic [COLOR_W-1:0]  ram_rdata;
    logic                start, issue, load_out, last_addr;
    logic [SQ_W-1:0]     sq_next [4];
    logic [DIST_W-1:0]   dist_sum;

    pnc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(q_item.index)),
        .wdata (q_item.pixel),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign last_addr = ((CNT_W'(addr_reg) + CNT_W'(1)) == search_count);

    // Sequence writes and scans
    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        q_pop      = 1'b0;
        start      = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.action == ACT_WRITE)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        start      = 1'b1;
                        state_next = (search_count == '0) ? ST_HOLD : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                issue = 1'b1;
                if (last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Squared channel differences of the returned entry
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            logic [CHAN_W-1:0] a, b, d;
            a = ram_rdata[c*CHAN_W +: CHAN_W];
            b = pixel_reg[c*CHAN_W +: CHAN_W];
            d = (a > b) ? (a - b) : (b - a);
            sq_next[c] = SQ_W'(d) * SQ_W'(d);
        end
    end

    assign dist_sum = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1])
                    + DIST_W'(sq_reg[2]) + DIST_W'(sq_reg[3]);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scan datapath: address, tag pipeline, best so far, result register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            addr_reg      <= '0;
            pixel_reg     <= q_item.pixel;
            best_idx_reg  <= '0;
            best_dist_reg <= NO_MATCH_DIST;
        end
        else
        begin
            if (issue)
            begin
                addr_reg <= addr_reg + AW'(1);
            end
            if (v2_reg && (RESULT_W'(dist_sum) <= best_dist_reg))
            begin
                best_idx_reg  <= idx2_reg;
                best_dist_reg <= RESULT_W'(dist_sum);
            end
        end
        idx1_reg <= addr_reg;
        idx2_reg <= idx1_reg;
        for (int c = 0; c < 4; c++)
        begin
            sq_reg[c] <= sq_next[c];
        end
        if (load_out)
        begin
            out_index_reg <= INDEX_W'(best_idx_reg);
            out_dist_reg  <= best_dist_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign color_index   = out_index_reg;
    assign best_distance = out_dist_reg;

endmodule

// File: rtl/palette_nearest_color.sv
// Palette nearest color search: maps ARGB pixels to the nearest palette index.
// Throughput: one entry compared per cycle, set by the single palette RAM read port.
// A two-entry queue lets intake continue while a scan runs or a result waits.
// Reset clears control and configuration (count 256, transparent 0); the
// palette contents are undefined until written.
module palette_nearest_color
    import pnc_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [COLOR_W-1:0]  cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic [INDEX_W-1:0]  entry_index,
    input  logic [CHAN_W-1:0]   alpha,
    input  logic [CHAN_W-1:0]   red,
    input  logic [CHAN_W-1:0]   green,
    input  logic [CHAN_W-1:0]   blue,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [INDEX_W-1:0]  color_index,
    output logic [RESULT_W-1:0] best_distance
);

    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

    logic             q_full, q_push, q_pop, q_valid;
    pnc_item_t        push_item, head_item;
    logic [CNT_W-1:0] search_count;

    // Intake and classification
    pnc_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .entry_index  (entry_index),
        .alpha        (alpha),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item),
        .search_count (search_count)
    );

    // Item queue
    pnc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    // Store writes and scan
    pnc_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .search_count  (search_count),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .color_index   (color_index),
        .best_distance (best_distance)
    );

endmodule
